[design/rgb_channel_histogram_unit_assert.svh]
// Assertion macros for the histogram unit and its checker
`ifndef RGB_CHANNEL_HISTOGRAM_UNIT_ASSERT_SVH
`define RGB_CHANNEL_HISTOGRAM_UNIT_ASSERT_SVH

// same-cycle implication
`define RCH_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rgb histogram check failed");

// next-cycle implication
`define RCH_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rgb histogram check failed");

`endif

[design/rhist_pkg.sv]
`timescale 1ns / 1ps

package rhist_pkg;

    localparam int BIN_COUNT   = 256;
    localparam int COUNT_WIDTH = 24;
    localparam int PIX_W       = 8;
    localparam int OUT_W       = 24;
    localparam int ADDR_W      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    localparam logic [PIX_W:0]         BIN_LIMIT = (PIX_W + 1)'(BIN_COUNT);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_blue;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_red;
        logic [PIX_W-1:0] read_bin;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] bin_echo;
        logic [OUT_W-1:0] red_count;
        logic [OUT_W-1:0] green_count;
        logic [OUT_W-1:0] blue_count;
    } result_t;

    typedef struct packed {
        logic              act;
        logic              clr;
        logic [ADDR_W-1:0] addr;
    } bank_req_t;

    function automatic logic in_bins(input logic [PIX_W-1:0] v);
        return {1'b0, v} < BIN_LIMIT;
    endfunction

    function automatic logic [ADDR_W-1:0] bin_addr(input logic [PIX_W-1:0] v);
        logic [PIX_W+ADDR_W-1:0] ext;
        ext = {{ADDR_W{1'b0}}, v};
        return ext[ADDR_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] c);
        logic [OUT_W+COUNT_WIDTH-1:0] ext;
        ext = {{OUT_W{1'b0}}, c};
        return ext[OUT_W-1:0];
    endfunction

endpackage

[design/rgb_channel_histogram_unit.sv]
`timescale 1ns / 1ps
// Read path: an accepted read transaction's bank counts and bin are registered in the
// read stage, then written into the result queue entry that drives result_valid.
// Throughput: one pixel transaction per cycle while item_stall is low; transactions
// stall while the read stage and the two-entry result queue hold two or more results.
// Reset: asynchronous, active low; per-bin valid flags clear every bin at once,
// so transactions are accepted as soon as reset is released.

module rgb_channel_histogram_unit
    import rhist_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic                   xact;
    bank_req_t              req_red;
    bank_req_t              req_green;
    bank_req_t              req_blue;
    logic [COUNT_WIDTH-1:0] cnt_red;
    logic [COUNT_WIDTH-1:0] cnt_green;
    logic [COUNT_WIDTH-1:0] cnt_blue;
    logic                   s1_read_reg;
    logic                   s1_hit_reg;
    logic [PIX_W-1:0]       s1_bin_reg;
    logic [1:0]             fill;
    logic [1:0]             pending;
    logic                   rd_hit;
    logic                   is_read;
    result_t                res;

    assign pending    = fill + {1'b0, s1_read_reg};
    assign item_stall = pending[1];
    assign xact       = item_valid && !item_stall;
    assign is_read    = (item.kind == KIND_READ);
    assign rd_hit     = in_bins(item.read_bin);

    always_comb
    begin
        req_red.clr   = is_read;
        req_green.clr = is_read;
        req_blue.clr  = is_read;
        if (is_read)
        begin
            req_red.act    = xact && rd_hit;
            req_green.act  = xact && rd_hit;
            req_blue.act   = xact && rd_hit;
            req_red.addr   = bin_addr(item.read_bin);
            req_green.addr = bin_addr(item.read_bin);
            req_blue.addr  = bin_addr(item.read_bin);
        end
        else
        begin
            req_red.act    = xact && in_bins(item.pixel_red);
            req_green.act  = xact && in_bins(item.pixel_green);
            req_blue.act   = xact && in_bins(item.pixel_blue);
            req_red.addr   = bin_addr(item.pixel_red);
            req_green.addr = bin_addr(item.pixel_green);
            req_blue.addr  = bin_addr(item.pixel_blue);
        end
    end

    rhist_bank u_bank_red
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_red),
        .count (cnt_red)
    );

    rhist_bank u_bank_green
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_green),
        .count (cnt_green)
    );

    rhist_bank u_bank_blue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_blue),
        .count (cnt_blue)
    );

    always_comb
    begin
        res.bin_echo = s1_bin_reg;
        if (s1_hit_reg)
        begin
            res.red_count   = to_out(cnt_red);
            res.green_count = to_out(cnt_green);
            res.blue_count  = to_out(cnt_blue);
        end
        else
        begin
            res.red_count   = '0;
            res.green_count = '0;
            res.blue_count  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_read_reg <= 1'b0;
            s1_hit_reg  <= 1'b0;
            s1_bin_reg  <= '0;
        end
        else
        begin
            s1_read_reg <= xact && is_read;
            s1_hit_reg  <= rd_hit;
            s1_bin_reg  <= item.read_bin;
        end
    end

    rhist_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_read_reg),
        .push_data (res),
        .valid     (result_valid),
        .stall     (result_stall),
        .data      (result),
        .fill      (fill)
    );

endmodule

[design/rhist_bank.sv]
`timescale 1ns / 1ps

module rhist_bank
    import rhist_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bank_req_t              req,
    output logic [COUNT_WIDTH-1:0] count
);

    logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [BIN_COUNT-1:0]   vld_reg;
    logic                   rd_vld_reg;
    bank_req_t              s1_reg;
    logic                   fwd_act_reg;
    logic [ADDR_W-1:0]      fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   fwd_hit;

    always_comb
    begin
        fwd_hit = fwd_act_reg && (fwd_addr_reg == s1_reg.addr);
        if (fwd_hit)
        begin
            count = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            count = rd_data_reg;
        end
        else
        begin
            count = '0;
        end
        if (s1_reg.clr)
        begin
            wr_data = '0;
        end
        else if (count == COUNT_MAX)
        begin
            wr_data = count;
        end
        else
        begin
            wr_data = count + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.act)
        begin
            rd_data_reg <= mem[req.addr];
        end
        if (s1_reg.act)
        begin
            mem[s1_reg.addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            s1_reg       <= '0;
            fwd_act_reg  <= 1'b0;
            fwd_addr_reg <= '0;
            fwd_data_reg <= '0;
        end
        else
        begin
            rd_vld_reg  <= vld_reg[req.addr];
            s1_reg      <= req;
            fwd_act_reg <= s1_reg.act;
            if (s1_reg.act)
            begin
                vld_reg[s1_reg.addr] <= 1'b1;
                fwd_addr_reg         <= s1_reg.addr;
                fwd_data_reg         <= wr_data;
            end
        end
    end

endmodule

[design/rhist_outq.sv]
`timescale 1ns / 1ps

module rhist_outq
    import rhist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    output logic        valid,
    input  logic        stall,
    output result_t     data,
    output logic [1:0]  fill
);

    result_t    ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       pop;

    assign valid = (fill_reg != 2'd0);
    assign data  = ent_reg[rd_ptr_reg];
    assign fill  = fill_reg;
    assign pop   = valid && !stall;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

[design/rhist_checker.sv]
`timescale 1ns / 1ps
`include "rgb_channel_histogram_unit_assert.svh"

module rhist_checker
    import rhist_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    `RCH_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    `RCH_ASSERT_NOW(a_idle_ready, clk, rst_n, !result_valid, !item_stall)
    `RCH_ASSERT_NOW(a_result_cause, clk, rst_n, $rose(result_valid), $past(item_valid && !item_stall && item.kind == KIND_READ, 2))
    `RCH_ASSERT_NOW(a_result_echo, clk, rst_n, $rose(result_valid), result.bin_echo == $past(item.read_bin, 2))

endmodule

bind rgb_channel_histogram_unit rhist_checker u_rhist_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
